/* hdl/tfn_pkg.sv */
// tfn_pkg: shared constants, types and a helper function for the triangle face normal block
// no dependencies
package tfn_pkg;

    localparam int FracBits  = 14;
    localparam int ScaleTop  = 31;
    localparam int CoordW    = 16;
    localparam int EdgeW     = 17;
    localparam int CrossW    = 35;
    localparam int MagW      = 34;
    localparam int NormW     = 31;
    localparam int SumW      = 64;
    localparam int RootW     = 32;
    localparam int QuotW     = 15;
    localparam int OutW      = 16;
    localparam int InDataW   = 144;
    localparam int OutDataW  = 48;

    // per-item side information carried down the pipe
    typedef struct packed {
        logic       degen;
        logic [2:0] neg;
    } t_side;

    // bit length of a 34-bit magnitude, 0..34
    function automatic logic [5:0] bit_len(input logic [MagW-1:0] v);
        logic [5:0] n;
        n = '0;
        for (int k = 0; k < MagW; k++) begin
            if (v[k]) begin
                n = 6'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

/* hdl/tfn_cross.sv */
// tfn_cross: edge vectors and exact cross product, three register stages
// depends on tfn_pkg
module tfn_cross (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [tfn_pkg::InDataW-1:0]          i_data,
    output logic                                 o_valid,
    output logic signed [tfn_pkg::CrossW-1:0]    o_c [3]
);
    logic signed [tfn_pkg::EdgeW-1:0]    r_e1 [3];
    logic signed [tfn_pkg::EdgeW-1:0]    r_e2 [3];
    logic signed [2*tfn_pkg::EdgeW-1:0]  r_pa [3];
    logic signed [2*tfn_pkg::EdgeW-1:0]  r_pb [3];
    logic signed [tfn_pkg::CrossW-1:0]   r_c  [3];
    logic [2:0]                          r_v;
    logic signed [tfn_pkg::CoordW-1:0]   w_p  [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_p[k] = signed'(i_data[k*tfn_pkg::CoordW +: tfn_pkg::CoordW]);
        end
    end

    // valid shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // edges, products, differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= tfn_pkg::EdgeW'(w_p[3+k]) - tfn_pkg::EdgeW'(w_p[k]);
                r_e2[k] <= tfn_pkg::EdgeW'(w_p[6+k]) - tfn_pkg::EdgeW'(w_p[k]);
            end
            r_pa[0] <= r_e1[1] * r_e2[2];
            r_pb[0] <= r_e1[2] * r_e2[1];
            r_pa[1] <= r_e1[2] * r_e2[0];
            r_pb[1] <= r_e1[0] * r_e2[2];
            r_pa[2] <= r_e1[0] * r_e2[1];
            r_pb[2] <= r_e1[1] * r_e2[0];
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= tfn_pkg::CrossW'(r_pa[k]) - tfn_pkg::CrossW'(r_pb[k]);
            end
        end
    end

    assign o_valid = r_v[2];
    assign o_c     = r_c;
endmodule

/* hdl/tfn_scale.sv */
// tfn_scale: magnitudes, common shift and sum of squares, five register stages
// depends on tfn_pkg
module tfn_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [tfn_pkg::CrossW-1:0]   i_c [3],
    output logic                                o_valid,
    output tfn_pkg::t_side                      o_side,
    output logic [tfn_pkg::NormW-1:0]           o_m [3],
    output logic [tfn_pkg::SumW-1:0]            o_sum
);
    logic [tfn_pkg::MagW-1:0]   r_a   [3];
    logic [5:0]                 r_bl;
    logic [tfn_pkg::MagW-1:0]   r_a2  [3];
    logic [tfn_pkg::NormW-1:0]  r_m   [3];
    logic [tfn_pkg::NormW-1:0]  r_m2  [3];
    logic [2*tfn_pkg::NormW-1:0] r_sq [3];
    logic [tfn_pkg::NormW-1:0]  r_m3  [3];
    logic [tfn_pkg::SumW-1:0]   r_sum;
    tfn_pkg::t_side             r_s   [4];
    logic [3:0]                 r_v;
    logic [tfn_pkg::MagW-1:0]   w_big;
    logic [tfn_pkg::MagW+30:0]  w_sh  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_comb begin
        w_big = r_a[0];
        if (r_a[1] > w_big) w_big = r_a[1];
        if (r_a[2] > w_big) w_big = r_a[2];
    end

    // normalizing shift of all three by one amount
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_bl <= 6'(tfn_pkg::ScaleTop)) begin
                w_sh[k] = {31'd0, r_a2[k]} << (6'(tfn_pkg::ScaleTop) - r_bl);
            end else begin
                w_sh[k] = {31'd0, r_a2[k] >> (r_bl - 6'(tfn_pkg::ScaleTop))};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage a: magnitudes and signs
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= i_c[k][tfn_pkg::CrossW-1] ? tfn_pkg::MagW'(-i_c[k])
                                                    : tfn_pkg::MagW'(i_c[k]);
                r_s[0].neg[k] <= i_c[k][tfn_pkg::CrossW-1];
            end
            r_s[0].degen <= (i_c[0] == '0) && (i_c[1] == '0) && (i_c[2] == '0);
            // stage b: bit length of largest
            r_bl <= tfn_pkg::bit_len(w_big);
            r_a2 <= r_a;
            // stage c: shift
            for (int k = 0; k < 3; k++) begin
                r_m[k] <= w_sh[k][tfn_pkg::NormW-1:0];
            end
            // stage d: squares
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= r_m[k] * r_m[k];
            end
            r_m2 <= r_m;
            // stage e: sum
            r_sum <= tfn_pkg::SumW'(r_sq[0]) + tfn_pkg::SumW'(r_sq[1])
                   + tfn_pkg::SumW'(r_sq[2]);
            r_m3 <= r_m2;
            for (int k = 1; k < 4; k++) begin
                r_s[k] <= r_s[k-1];
            end
        end
    end

    logic r_v4;
    tfn_pkg::t_side r_s4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v[3];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4 <= r_s[3];
        end
    end

    assign o_valid = r_v4;
    assign o_side  = r_s4;
    assign o_m     = r_m3;
    assign o_sum   = r_sum;
endmodule

/* hdl/tfn_sqrt.sv */
// tfn_sqrt: pipelined integer square root, two result bits per stage
// depends on tfn_pkg
module tfn_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  tfn_pkg::t_side                   i_side,
    input  logic [tfn_pkg::NormW-1:0]        i_m [3],
    input  logic [tfn_pkg::SumW-1:0]         i_sum,
    output logic                             o_valid,
    output tfn_pkg::t_side                   o_side,
    output logic [tfn_pkg::NormW-1:0]        o_m [3],
    output logic [tfn_pkg::RootW-1:0]        o_len
);
    localparam int Steps = tfn_pkg::RootW / 2;

    logic [tfn_pkg::SumW-1:0]   r_rem  [Steps];
    logic [tfn_pkg::RootW-1:0]  r_root [Steps];
    logic [tfn_pkg::SumW-1:0]   r_s    [Steps];
    logic [tfn_pkg::NormW-1:0]  r_m    [Steps][3];
    tfn_pkg::t_side             r_sd   [Steps];
    logic [Steps-1:0]           r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Steps-2:0], i_valid};
        end
    end

    // restoring root, two result bits per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int st = 0; st < Steps; st++) begin
                logic [tfn_pkg::SumW-1:0]  rem;
                logic [tfn_pkg::RootW-1:0] root;
                logic [tfn_pkg::SumW-1:0]  src;
                logic [tfn_pkg::SumW+1:0]  trial;
                logic [tfn_pkg::SumW-1:0]  rr;
                rem  = (st == 0) ? '0 : r_rem[st-1];
                root = (st == 0) ? '0 : r_root[st-1];
                src  = (st == 0) ? i_sum : r_s[st-1];
                for (int j = 0; j < 2; j++) begin
                    rr    = {rem[tfn_pkg::SumW-3:0], src[tfn_pkg::SumW-1 -: 2]};
                    src   = src << 2;
                    trial = {2'b0, rr} - {{(tfn_pkg::SumW-tfn_pkg::RootW){1'b0}},
                                          root, 2'b01};
                    if (!trial[tfn_pkg::SumW+1]) begin
                        rem  = trial[tfn_pkg::SumW-1:0];
                        root = {root[tfn_pkg::RootW-2:0], 1'b1};
                    end else begin
                        rem  = rr;
                        root = {root[tfn_pkg::RootW-2:0], 1'b0};
                    end
                end
                r_rem[st]  <= rem;
                r_root[st] <= root;
                r_s[st]    <= src;
                if (st == 0) begin
                    r_m[st] <= i_m;
                end else begin
                    r_m[st] <= r_m[st-1];
                end
                r_sd[st]   <= (st == 0) ? i_side : r_sd[st-1];
            end
        end
    end

    assign o_valid = r_v[Steps-1];
    assign o_side  = r_sd[Steps-1];
    assign o_m     = r_m[Steps-1];
    assign o_len   = r_root[Steps-1];
endmodule

/* hdl/tfn_div.sv */
// tfn_div: pipelined restoring divide, one quotient bit per stage, then rounding and sign
// depends on tfn_pkg
module tfn_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  tfn_pkg::t_side                     i_side,
    input  logic [tfn_pkg::NormW-1:0]          i_m [3],
    input  logic [tfn_pkg::RootW-1:0]          i_len,
    output logic                               o_valid,
    output logic                               o_degen,
    output logic signed [tfn_pkg::OutW-1:0]    o_n [3]
);
    // quotient of m*2^15 / len has 16 bits (m <= len); last bit rounds
    localparam int Bits = tfn_pkg::QuotW + 1;
    localparam int RemW = tfn_pkg::RootW + 1;

    logic [RemW-1:0]            r_rem [Bits][3];
    logic [Bits-1:0]            r_q   [Bits][3];
    logic [tfn_pkg::RootW-1:0]  r_len [Bits];
    tfn_pkg::t_side             r_sd  [Bits];
    logic [Bits-1:0]            r_v;
    logic signed [tfn_pkg::OutW-1:0] r_n [3];
    logic                       r_dg;
    logic                       r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[Bits-2:0], i_valid};
            r_vo <= r_v[Bits-1];
        end
    end

    // long division; first stage takes the integer bit m / len
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int st = 0; st < Bits; st++) begin
                for (int k = 0; k < 3; k++) begin
                    logic [RemW-1:0] rr;
                    logic [Bits-1:0] q;
                    logic [tfn_pkg::RootW-1:0] d;
                    d  = (st == 0) ? i_len : r_len[st-1];
                    rr = (st == 0) ? RemW'(i_m[k])
                                   : {r_rem[st-1][k][RemW-2:0], 1'b0};
                    q  = (st == 0) ? '0 : r_q[st-1][k];
                    if (rr >= RemW'(d)) begin
                        rr = rr - RemW'(d);
                        q  = {q[Bits-2:0], 1'b1};
                    end else begin
                        q  = {q[Bits-2:0], 1'b0};
                    end
                    r_rem[st][k] <= rr;
                    r_q[st][k]   <= q;
                end
                r_len[st] <= (st == 0) ? i_len : r_len[st-1];
                r_sd[st]  <= (st == 0) ? i_side : r_sd[st-1];
            end
            // round half up on the magnitude, then apply sign
            for (int k = 0; k < 3; k++) begin
                logic [Bits-1:0] mag;
                mag = (r_q[Bits-1][k] + Bits'(1)) >> 1;
                if (r_sd[Bits-1].degen) begin
                    r_n[k] <= '0;
                end else if (r_sd[Bits-1].neg[k]) begin
                    r_n[k] <= -signed'(tfn_pkg::OutW'(mag));
                end else begin
                    r_n[k] <= signed'(tfn_pkg::OutW'(mag));
                end
            end
            r_dg <= r_sd[Bits-1].degen;
        end
    end

    assign o_valid = r_vo;
    assign o_degen = r_dg;
    assign o_n     = r_n;

    // a flagged result carries a zero normal
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degen |-> (o_n[0] == '0) && (o_n[1] == '0) && (o_n[2] == '0))
        else $error("degenerate result with nonzero normal");
    // normal components stay within unit range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_n[0] <= 16384) && (o_n[0] >= -16384)
                 && (o_n[1] <= 16384) && (o_n[1] >= -16384)
                 && (o_n[2] <= 16384) && (o_n[2] >= -16384))
        else $error("normal component out of range");
    // frozen pipe keeps its output valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en && o_valid |=> o_valid)
        else $error("valid lost during stall");
endmodule

/* hdl/triangle_face_normal.sv */
// triangle_face_normal: top level, triangle corners in, unit face normal out
// depends on tfn_pkg, tfn_cross, tfn_scale, tfn_sqrt, tfn_div
//
// Usage:
//   s_axis carries one triangle per transaction: nine signed 16-bit corner
//   coordinates. m_axis carries one result per triangle: a unit normal as
//   three signed Q1.14 values rounded to nearest, and a degenerate flag in
//   tuser that is set (with a zero normal) when the cross product is zero.
//   Throughput: one triangle per clock while the receiver accepts results.
//   Stages in order: cross product, scaling, square root, divide, then
//   rounding with the output register.
//   The whole pipeline advances as one; when the receiver stalls with a
//   result waiting, it freezes and s_axis_tready drops, so nothing is lost
//   or repeated. Empty slots never block: tready stays high while the
//   output register is free.
//   Reset (synchronous, active low) clears all valid bits; payload is not
//   cleared. Results order equals input order.
module triangle_face_normal (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  logic [tfn_pkg::InDataW-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [tfn_pkg::OutDataW-1:0]       m_axis_tdata,
    // degenerate
    output logic                               m_axis_tuser
);
    logic                               w_en;
    logic                               w_cv, w_sv, w_rv;
    logic signed [tfn_pkg::CrossW-1:0]  w_c [3];
    tfn_pkg::t_side                     w_ss, w_rs;
    logic [tfn_pkg::NormW-1:0]          w_sm [3];
    logic [tfn_pkg::NormW-1:0]          w_rm [3];
    logic [tfn_pkg::SumW-1:0]           w_sum;
    logic [tfn_pkg::RootW-1:0]          w_len;
    logic signed [tfn_pkg::OutW-1:0]    w_n [3];

    // pipe moves unless a result is waiting unaccepted
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    tfn_cross u_cross (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(s_axis_tvalid), .i_data(s_axis_tdata),
        .o_valid(w_cv), .o_c(w_c)
    );

    tfn_scale u_scale (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_cv), .i_c(w_c),
        .o_valid(w_sv), .o_side(w_ss), .o_m(w_sm), .o_sum(w_sum)
    );

    tfn_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_sv), .i_side(w_ss), .i_m(w_sm), .i_sum(w_sum),
        .o_valid(w_rv), .o_side(w_rs), .o_m(w_rm), .o_len(w_len)
    );

    tfn_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(w_rv), .i_side(w_rs), .i_m(w_rm), .i_len(w_len),
        .o_valid(m_axis_tvalid), .o_degen(m_axis_tuser), .o_n(w_n)
    );

    assign m_axis_tdata = {w_n[2], w_n[1], w_n[0]};
endmodule
